>>> hw/rtl/jdc_pkg.sv
package jdc_pkg;

  // Day number of the day before 1 Mar of year 0 (shifted year count)
  localparam logic [21:0] EpochToJdn = 22'd1721117;

  // Supported span: 1 Jan -32768 .. 31 Dec 32767
  localparam logic signed [24:0] JdnLo = -25'sd10247088;
  localparam logic signed [24:0] JdnHi = 25'sd13689569;

  // Days in a four-year cycle
  localparam logic [10:0] DaysIn4y = 11'd1461;

  // Inverse path: u = 4*(jd - 1721118) + 3 + 1461*32768, always positive in span
  localparam logic [27:0] UOffset = 28'd40989579;

  // floor(2^37 / 1461); estimate is the exact quotient or one below
  localparam logic [26:0] Recip4y = 27'd94071836;
  localparam int unsigned RecipShift = 37;

  // Bias added to the cycle quotient by UOffset
  localparam logic [16:0] QBias = 17'd32768;

  // Month index counted from March (0 = Mar .. 11 = Feb)
  localparam logic [3:0] IdxJan = 4'd10;

  // Date fields shared by both conversion paths
  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               leap;
    logic [4:0]         mlen;
  } date_t;

  // Day offset of a month within a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    unique case (idx)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  // Days in a month, zero for a month code outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:                                       return leap ? 5'd29 : 5'd28;
      default:                                    return 5'd0;
    endcase
  endfunction

endpackage

>>> hw/rtl/jdc_fwd.sv
// Date to day number: check, scale the shifted year by 1461, add month offset
module jdc_fwd import jdc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] year,
  input  logic [3:0]         month,
  input  logic [5:0]         day,
  output logic signed [24:0] jd,
  output date_t              date,
  output logic               ok
);

  // stage 1 signals
  logic signed [16:0] ya;
  logic signed [16:0] yc;
  logic               leap;
  logic [4:0]         mlen;
  logic               ok_c;
  logic [3:0]         idx;
  logic [21:0]        jconst;

  logic signed [16:0] yc1;
  logic [21:0]        jc1;
  logic               ok1;
  date_t              date1;

  logic signed [27:0] prod;
  logic signed [27:0] p2;
  logic [21:0]        jc2;
  logic               ok2;
  date_t              date2;

  logic signed [26:0] sum;
  logic signed [24:0] jd3;
  logic               ok3;
  date_t              date3;

  // Stage 1: no year zero, leap test, validity, month offset
  always_comb begin
    ya     = {year[15], year} + (year[15] ? 17'sd1 : 17'sd0);
    yc     = ya - ((month < 4'd3) ? 17'sd1 : 17'sd0);
    leap   = (ya[1:0] == 2'b00);
    mlen   = month_len(month, leap);
    ok_c   = (year != 16'sd0) && (mlen != 5'd0) && (day != 6'd0) &&
             (day <= {1'b0, mlen});
    idx    = (month >= 4'd3) ? (month - 4'd3) : (month + 4'd9);
    jconst = EpochToJdn + {13'd0, month_start(idx)} + {16'd0, day};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yc1        <= yc;
      jc1        <= jconst;
      ok1        <= ok_c;
      date1.year  <= year;
      date1.month <= month;
      date1.day   <= day[4:0];
      date1.leap  <= leap;
      date1.mlen  <= mlen;
    end
  end

  // Stage 2: days in whole four-year cycles
  assign prod = $signed({{11{yc1[16]}}, yc1}) * $signed({17'd0, DaysIn4y});

  always_ff @(posedge clk) begin
    if (en) begin
      p2    <= prod;
      jc2   <= jc1;
      ok2   <= ok1;
      date2 <= date1;
    end
  end

  // Stage 3: floor divide by 4 and add the constant part
  assign sum = $signed({p2[27], p2[27:2]}) + $signed({5'd0, jc2});

  always_ff @(posedge clk) begin
    if (en) begin
      jd3   <= sum[24:0];
      ok3   <= ok2;
      date3 <= date2;
    end
  end

  // Stage 4: align with the inverse path
  always_ff @(posedge clk) begin
    if (en) begin
      jd   <= jd3;
      ok   <= ok3;
      date <= date3;
    end
  end

endmodule

>>> hw/rtl/jdc_inv.sv
// Day number to date: reciprocal divide by 1461, then split the year into months
module jdc_inv import jdc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [24:0] jd_in,
  output logic signed [24:0] jd,
  output date_t              date,
  output logic               ok
);

  logic signed [27:0] u_full;
  logic               in_span;
  logic [26:0]        u1;
  logic signed [24:0] jd1;
  logic               ok1;

  logic [53:0]        prod;
  logic [26:0]        u2;
  logic [16:0]        q2;
  logic signed [24:0] jd2;
  logic               ok2;

  logic [27:0]        rem_full;
  logic [11:0]        rem3;
  logic [16:0]        q3;
  logic signed [24:0] jd3;
  logic               ok3;

  logic [10:0]        remc;
  logic [16:0]        qc;
  logic [8:0]         doy;
  logic [3:0]         cnt;
  logic [16:0]        q4;
  logic [8:0]         d4;
  logic [3:0]         x4;

  logic signed [16:0] qs;
  logic               carry;
  logic signed [16:0] yy;
  logic signed [16:0] yout;
  logic [3:0]         mon;
  logic [8:0]         dom;

  // Stage 1: span check and biased cycle numerator
  always_comb begin
    u_full  = $signed({jd_in[24], jd_in, 2'b00}) + $signed(UOffset);
    in_span = (jd_in >= JdnLo) && (jd_in <= JdnHi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1  <= u_full[26:0];
      jd1 <= jd_in;
      ok1 <= in_span;
    end
  end

  // Stage 2: quotient estimate by reciprocal multiply
  assign prod = {27'd0, u1} * {27'd0, Recip4y};

  always_ff @(posedge clk) begin
    if (en) begin
      q2  <= prod[RecipShift +: 17];
      u2  <= u1;
      jd2 <= jd1;
      ok2 <= ok1;
    end
  end

  // Stage 3: raw remainder, below twice the divisor
  assign rem_full = {1'b0, u2} - ({11'd0, q2} * {17'd0, DaysIn4y});

  always_ff @(posedge clk) begin
    if (en) begin
      rem3 <= rem_full[11:0];
      q3   <= q2;
      jd3  <= jd2;
      ok3  <= ok2;
    end
  end

  // Stage 4: correct quotient, day of year, month index by threshold count
  always_comb begin
    if (rem3 >= {1'b0, DaysIn4y}) begin
      remc = 11'(rem3 - {1'b0, DaysIn4y});
      qc   = q3 + 17'd1;
    end else begin
      remc = rem3[10:0];
      qc   = q3;
    end
    doy = remc[10:2];
    cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= month_start(4'(k))) cnt = cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q4  <= qc;
      d4  <= doy;
      x4  <= cnt;
      jd  <= jd3;
      ok  <= ok3;
    end
  end

  // Date assembly from the stage 4 registers
  always_comb begin
    qs    = $signed(q4 - QBias);
    carry = (x4 >= IdxJan);
    yy    = qs + (carry ? 17'sd1 : 17'sd0);
    yout  = (yy <= 17'sd0) ? (yy - 17'sd1) : yy;
    mon   = carry ? (x4 - 4'd9) : (x4 + 4'd3);
    dom   = d4 - month_start(x4) + 9'd1;
    date.year  = yout[15:0];
    date.month = mon;
    date.day   = dom[4:0];
    date.leap  = (yy[1:0] == 2'b00);
    date.mlen  = month_len(mon, date.leap);
  end

endmodule

>>> hw/rtl/julian_date_day_number_converter.sv
// Julian calendar date <-> Julian day number, proleptic, no year zero. Each
// request picks its direction by s_tuser (0: date to day number, 1: day number
// to date). One request enters per cycle while s_tready is high, and its result
// passes through the four pipeline stages and the output register before it is
// presented on the output. The whole pipeline moves together, so throughput
// is one result per cycle for as long as m_tready stays high. The deepest stage
// holds the 27x27 reciprocal multiply that divides by the 1461-day cycle. A bad
// date, year zero, or a day number outside -10247088..13689569 yields an
// all-zero result with valid_res low.
module julian_date_day_number_converter import jdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // in_year[15:0], in_month[19:16], in_day[25:20], day_number[50:26], zero[55:51]
  input  logic [55:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_day_number[24:0], out_year[40:25], out_month[44:41], out_day[49:45],
  // leap_year[50], month_length[55:51]
  output logic [55:0] m_tdata,
  // valid_res[0]
  output logic        m_tuser
);

  logic               adv;
  logic [3:0]         vld;
  logic [3:0]         cmd;

  logic signed [24:0] fwd_jd;
  date_t              fwd_date;
  logic               fwd_ok;
  logic signed [24:0] inv_jd;
  date_t              inv_date;
  logic               inv_ok;

  logic signed [24:0] sel_jd;
  date_t              sel_date;
  logic               sel_ok;

  // Pipeline moves when the output register is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  jdc_fwd u_fwd (
    .clk   (clk),
    .en    (adv),
    .year  ($signed(s_tdata[15:0])),
    .month (s_tdata[19:16]),
    .day   (s_tdata[25:20]),
    .jd    (fwd_jd),
    .date  (fwd_date),
    .ok    (fwd_ok)
  );

  jdc_inv u_inv (
    .clk   (clk),
    .en    (adv),
    .jd_in ($signed(s_tdata[50:26])),
    .jd    (inv_jd),
    .date  (inv_date),
    .ok    (inv_ok)
  );

  // Valid bits and command travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 4'd0;
    end else if (adv) begin
      vld <= {vld[2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd <= {cmd[2:0], s_tuser};
    end
  end

  // Pick the direction's result
  always_comb begin
    if (cmd[3]) begin
      sel_jd   = inv_jd;
      sel_date = inv_date;
      sel_ok   = inv_ok;
    end else begin
      sel_jd   = fwd_jd;
      sel_date = fwd_date;
      sel_ok   = fwd_ok;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sel_ok) begin
        m_tdata <= {sel_date.mlen, sel_date.leap, sel_date.day, sel_date.month,
                    sel_date.year, sel_jd};
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= 56'd0;
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import jdc_pkg::*;

  // Direction of a request, carried on s_tuser
  typedef enum logic {
    CmdToDayNumber = 1'b0,
    CmdToDate      = 1'b1
  } conv_cmd_t;

  // One result as it appears on {m_tuser, m_tdata}
  typedef struct packed {
    logic               valid_res;
    logic [4:0]         month_length;
    logic               leap_year;
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic signed [15:0] out_year;
    logic signed [24:0] out_day_number;
  } conv_result_t;

  localparam int RequestCount  = 900;
  localparam int IdleLimit     = 5000;
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles   = 20;

  // Calendar arithmetic constants
  localparam longint EpochToJdn   = 1721117;
  localparam longint EpochFromJdn = 1721118;
  localparam longint Days4y       = 1461;
  localparam longint Days5m       = 153;
  localparam longint MonthShift   = 1836;
  localparam longint MonthOffset  = 457;
  localparam longint MonthsPerYr  = 12;
  localparam longint Five         = 5;

  // Predicts each conversion and holds the results still to come
  class julian_conversion_model;
    conv_result_t pending_conversions[$];
    int failures;
    int matched;
    int valid_results;
    int to_jdn_requests;
    int to_date_requests;

    function new();
      failures = 0;
      matched = 0;
      valid_results = 0;
      to_jdn_requests = 0;
      to_date_requests = 0;
    endfunction

    static function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
      return q;
    endfunction

    static function longint fmod(longint a, longint b);
      return a - b * fdiv(a, b);
    endfunction

    // No year zero: 1 BC behaves like year 0 of the four-year cycle
    static function logic is_leap(longint yr);
      if (yr < 0) yr++;
      return fmod(yr, 4) == 0;
    endfunction

    static function longint days_in_month(longint mon, longint yr);
      case (mon)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return is_leap(yr) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    static function longint date_to_day_number(longint yr, longint mon, longint dom);
      longint c0, j1, j2;
      if (yr < 0) yr++;
      c0 = fdiv(mon - 3, MonthsPerYr);
      j1 = fdiv(Days4y * (yr + c0), 4);
      j2 = fdiv(Days5m * mon - MonthShift * c0 - MonthOffset, Five);
      return j1 + j2 + dom + EpochToJdn;
    endfunction

    static function void day_number_to_date(input longint jd, output longint yr,
                                            output longint mon, output longint dom);
      longint y2, k2, k1, x1, c0;
      y2 = jd - EpochFromJdn;
      k2 = 4 * y2 + 3;
      k1 = Five * fdiv(fmod(k2, Days4y), 4) + 2;
      x1 = fdiv(k1, Days5m);
      c0 = fdiv(x1 + 2, MonthsPerYr);
      yr = fdiv(k2, Days4y) + c0;
      if (yr <= 0) yr--;
      mon = x1 - MonthsPerYr * c0 + 3;
      dom = fdiv(fmod(k1, Days5m), Five) + 1;
    endfunction

    // Accepted request: work out its result
    function void note_request(conv_cmd_t cmd, logic [55:0] req);
      conv_result_t res;
      longint yr, mon, dom, jd, mlen;
      logic ok;
      yr = longint'($signed(req[15:0]));
      mon = longint'(req[19:16]);
      dom = longint'(req[25:20]);
      jd = longint'($signed(req[50:26]));
      res = '0;
      mlen = 0;
      if (cmd == CmdToDayNumber) begin
        to_jdn_requests++;
        mlen = days_in_month(mon, yr);
        ok = (yr != 0) && (mlen != 0) && (dom >= 1) && (dom <= mlen);
        if (ok) jd = date_to_day_number(yr, mon, dom);
      end else begin
        to_date_requests++;
        ok = (jd >= date_to_day_number(-32768, 1, 1)) &&
             (jd <= date_to_day_number(32767, 12, 31));
        if (ok) begin
          day_number_to_date(jd, yr, mon, dom);
          mlen = days_in_month(mon, yr);
        end
      end
      if (ok) begin
        res.valid_res = 1'b1;
        res.month_length = mlen[4:0];
        res.leap_year = is_leap(yr);
        res.out_day = dom[4:0];
        res.out_month = mon[3:0];
        res.out_year = yr[15:0];
        res.out_day_number = jd[24:0];
      end
      pending_conversions.push_back(res);
    endfunction

    // Accepted result: compare with the oldest prediction
    function void check_result(logic [55:0] data, logic vres);
      conv_result_t got, want;
      got = {vres, data};
      if (pending_conversions.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: result with nothing pending: %h", got);
        return;
      end
      want = pending_conversions.pop_front();
      if (got.valid_res !== want.valid_res || got.month_length !== want.month_length ||
          got.leap_year !== want.leap_year || got.out_day !== want.out_day ||
          got.out_month !== want.out_month || got.out_year !== want.out_year ||
          got.out_day_number !== want.out_day_number) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: expected jdn=%0d y=%0d m=%0d d=%0d leap=%0d len=%0d ok=%0d",
                   want.out_day_number, want.out_year, want.out_month, want.out_day,
                   want.leap_year, want.month_length, want.valid_res);
          $display("       actual   jdn=%0d y=%0d m=%0d d=%0d leap=%0d len=%0d ok=%0d",
                   got.out_day_number, got.out_year, got.out_month, got.out_day,
                   got.leap_year, got.month_length, got.valid_res);
        end
      end else begin
        matched++;
      end
      if (want.valid_res) valid_results++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;

  julian_conversion_model julian_model;
  int  requests_sent;
  int  cycle_count;
  bit  long_hold_done;

  julian_date_day_number_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request from a negedge until it is taken
  task automatic send_request(input conv_cmd_t cmd, input logic [55:0] req);
    int gap;
    gap = ((requests_sent / 64) % 4 == 3) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= req;
    do @(posedge clk); while (!s_tready);
    julian_model.note_request(cmd, req);
    requests_sent++;
    @(negedge clk);
  endtask

  // Date request; the unused day number carries noise
  task automatic send_date(input logic signed [15:0] yr, input logic [3:0] mon,
                           input logic [5:0] dom);
    logic [24:0] noise;
    noise = 25'($urandom);
    send_request(CmdToDayNumber, {5'b0, noise, dom, mon, yr});
  endtask

  // Day number request; the unused date fields carry noise
  task automatic send_jdn(input logic signed [24:0] jd);
    logic [25:0] noise;
    noise = 26'($urandom);
    send_request(CmdToDate, {5'b0, jd, noise});
  endtask

  // Random date: well formed with a nonzero year, or else a bad day or year zero
  task automatic send_random_date(input bit well_formed);
    logic signed [15:0] yr;
    logic [3:0] mon;
    int mlen;
    if ($urandom_range(0, 9) < 7) yr = 16'($urandom);
    else yr = 16'($urandom_range(0, 100) - 50);
    if (yr == 0) yr = -16'sd1;
    mon = 4'($urandom_range(1, 12));
    mlen = int'(julian_conversion_model::days_in_month(longint'(mon), longint'(yr)));
    if (well_formed) send_date(yr, mon, 6'($urandom_range(1, mlen)));
    else begin
      case ($urandom_range(0, 2))
        0:       send_date(yr, mon, 6'(mlen + 1));
        1:       send_date(yr, mon, 6'd0);
        default: send_date(16'sd0, mon, 6'($urandom_range(1, mlen)));
      endcase
    end
  endtask

  // Monitor: every accepted result is checked
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready)
      julian_model.check_result(m_tdata, m_tuser);
  end

  // Receiver: random stalls, one long hold-off while requests keep coming
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin : ready_loop
      int gap;
      if (!long_hold_done && requests_sent >= 300) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
      end
      if ((cycle_count / 256) % 4 == 1) gap = 0;
      else gap = pick_gap();
      if (gap == 0) begin
        m_tready <= 1'b1;
        @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("ERROR: no handshake for %0d cycles", IdleLimit);
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence
  initial begin
    int r;
    longint jd;
    julian_model = new();
    requests_sent = 0;
    cycle_count = 0;
    long_hold_done = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: span ends, era boundary, leap rules, bad fields
    send_date(16'sd1, 4'd1, 6'd1);
    send_date(-16'sd1, 4'd12, 6'd31);
    send_date(16'sd0, 4'd6, 6'd15);
    send_date(-16'sd32768, 4'd1, 6'd1);
    send_date(16'sd32767, 4'd12, 6'd31);
    send_date(16'sd4, 4'd2, 6'd29);
    send_date(16'sd3, 4'd2, 6'd29);
    send_date(-16'sd1, 4'd2, 6'd29);
    send_date(-16'sd5, 4'd2, 6'd29);
    send_date(16'sd2024, 4'd2, 6'd30);
    send_date(16'sd1999, 4'd4, 6'd31);
    send_date(16'sd1999, 4'd0, 6'd10);
    send_date(16'sd1999, 4'd13, 6'd10);
    send_date(-16'sd32768, 4'd15, 6'd63);
    send_date(16'sd1999, 4'd5, 6'd0);
    send_date(16'sd1999, 4'd5, 6'd63);
    send_jdn(JdnLo);
    send_jdn(JdnLo - 25'sd1);
    send_jdn(JdnHi);
    send_jdn(JdnHi + 25'sd1);
    send_jdn(-25'sd16777216);
    send_jdn(25'sd16777215);
    send_jdn(25'sd0);
    send_jdn(-25'sd1);
    send_jdn(25'sd1721424);
    send_jdn(25'sd1721423);

    // Random: mostly convertible requests, some noise
    repeat (RequestCount) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_random_date(1'b1);
      else if (r < 52) send_date(16'($urandom), 4'($urandom), 6'($urandom));
      else if (r < 58) send_random_date(1'b0);
      else if (r < 80) begin
        jd = longint'(JdnLo) +
             longint'($urandom_range(0, 32'(longint'(JdnHi) - longint'(JdnLo))));
        send_jdn(jd[24:0]);
      end else if (r < 92) begin
        // Near the start of a month, where year and month roll over
        jd = julian_conversion_model::date_to_day_number(
               longint'($urandom_range(0, 65535)) - 32768 + 0,
               longint'($urandom_range(1, 12)), 1) +
             longint'($urandom_range(0, 2)) - 1;
        send_jdn(jd[24:0]);
      end else begin
        send_jdn(25'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (julian_model.pending_conversions.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Checked %0d results: %0d date to day number, %0d day number to date, %0d valid.",
             julian_model.matched + julian_model.failures,
             julian_model.to_jdn_requests, julian_model.to_date_requests,
             julian_model.valid_results);
    $display("Receiver stalled at random and held off %0d cycles once under load.",
             LongHoldCycles);
    if (julian_model.failures == 0 && julian_model.pending_conversions.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
